// ===== src/tcpbd_pkg.sv =====
// tcpbd_pkg: shared types and constants for the three-class prefix byte decoder
// no dependencies; imported by the interfaces, controller, datapath and top level

package tcpbd_pkg;

    localparam int BYTE_W       = 8;
    localparam int COUNT_W      = 24;
    localparam int TABLE_LEN    = 20;
    localparam int COMMON_LEN   = 4;
    localparam int FILL_W       = 5;
    localparam int BUF_W        = 32;
    localparam int HOLD_W       = 6;
    localparam int REFILL_LIMIT = 24;
    localparam int PAD_LIMIT    = 8;
    localparam int PAD_W        = 4;

    typedef enum logic [1:0] {
        STATUS_DATA  = 2'd0,
        STATUS_TRUNC = 2'd1,
        STATUS_SHORT = 2'd2,
        STATUS_EMPTY = 2'd3
    } result_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROC,
        ST_SHORT,
        ST_LOOP
    } ctrl_state_t;

    typedef struct packed {
        logic           load_item;
        logic           clear_job;
        logic           set_finished;
        logic           table_write;
        logic           shift_in;
        logic           pad;
        logic           emit_sym;
        logic           emit_status;
        result_status_t code;
    } dp_cmd_t;

    typedef struct packed {
        logic job_finished;
        logic count_reached;
        logic table_full;
        logic table_last;
        logic at_end;
        logic buf_low;
        logic pads_full;
        logic slot_free;
        logic sym_done;
    } dp_status_t;

endpackage

// ===== src/tcpbd_ifs.sv =====
// tcpbd_in_if / tcpbd_out_if: valid-ready channels for compressed and decoded items
// depends on tcpbd_pkg for field widths

interface tcpbd_in_if
    import tcpbd_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              stream_end;

    modport source (output valid, output in_byte, output stream_end, input ready);
    modport sink (input valid, input in_byte, input stream_end, output ready);
endinterface

interface tcpbd_out_if
    import tcpbd_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic [1:0]        status;
    logic              last;

    modport source (output valid, output out_byte, output status, output last, input ready);
    modport sink (input valid, input out_byte, input status, input last, output ready);
endinterface

// ===== src/tcpbd_ctrl.sv =====
// tcpbd_ctrl: sequencer for the decoder, one input item at a time
// depends on tcpbd_pkg (state enum, command and status structs)

module tcpbd_ctrl
    import tcpbd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t sts,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.code   = STATUS_DATA;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_PROC;
                end
            end
            ST_PROC:
            begin
                priority if (sts.job_finished)
                begin
                    // bytes after completion are dropped until the stream end
                    cmd.clear_job = sts.at_end;
                    state_next    = ST_IDLE;
                end
                else if (sts.count_reached)
                begin
                    if (sts.slot_free)
                    begin
                        cmd.emit_status  = 1'b1;
                        cmd.code         = STATUS_EMPTY;
                        cmd.clear_job    = sts.at_end;
                        cmd.set_finished = !sts.at_end;
                        state_next       = ST_IDLE;
                    end
                end
                else if (!sts.table_full)
                begin
                    cmd.table_write = 1'b1;
                    priority if (sts.table_last)
                    begin
                        state_next = ST_LOOP;
                    end
                    else if (sts.at_end)
                    begin
                        state_next = ST_SHORT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.shift_in = 1'b1;
                    state_next   = ST_LOOP;
                end
            end
            ST_SHORT:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit_status = 1'b1;
                    cmd.code        = STATUS_SHORT;
                    cmd.clear_job   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_LOOP:
            begin
                priority if (sts.buf_low)
                begin
                    priority if (!sts.at_end)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (sts.pads_full)
                    begin
                        // a ninth pad byte would be needed
                        if (sts.slot_free)
                        begin
                            cmd.emit_status = 1'b1;
                            cmd.code        = STATUS_TRUNC;
                            cmd.clear_job   = 1'b1;
                            state_next      = ST_IDLE;
                        end
                    end
                    else
                    begin
                        cmd.pad = 1'b1;
                    end
                end
                else if (sts.slot_free)
                begin
                    cmd.emit_sym = 1'b1;
                    if (sts.sym_done)
                    begin
                        cmd.clear_job    = sts.at_end;
                        cmd.set_finished = !sts.at_end;
                        state_next       = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_sym || cmd.emit_status) |-> sts.slot_free)
        else $error("result pushed into an occupied output register");

    a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.emit_sym && cmd.emit_status) && !(cmd.load_item && state_reg != ST_IDLE))
        else $error("conflicting controller commands");

endmodule

// ===== src/tcpbd_dp.sv =====
// tcpbd_dp: code table, bit buffer, counters and output register of the decoder
// depends on tcpbd_pkg (constants, command and status structs)

module tcpbd_dp
    import tcpbd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [COUNT_W-1:0] cfg_wdata,
    input  logic [BYTE_W-1:0]  in_byte,
    input  logic               stream_end,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [BYTE_W-1:0]  out_byte,
    output logic [1:0]         out_status,
    output logic               out_last,
    input  dp_cmd_t            cmd,
    output dp_status_t         sts
);

    logic [COUNT_W-1:0] out_count_reg;
    logic [BYTE_W-1:0]  code_table [TABLE_LEN];
    logic [FILL_W-1:0]  table_fill_reg;
    logic [BUF_W-1:0]   bit_buffer_reg;
    logic [HOLD_W-1:0]  bits_held_reg;
    logic [COUNT_W-1:0] bytes_emitted_reg;
    logic               job_finished_reg;
    logic [PAD_W-1:0]   pad_cnt_reg;
    logic [BYTE_W-1:0]  item_byte_reg;
    logic               item_end_reg;
    logic               out_valid_reg;
    logic [BYTE_W-1:0]  out_byte_reg;
    logic [1:0]         out_status_reg;
    logic               out_last_reg;

    logic [HOLD_W-1:0]  pos2;
    logic [HOLD_W-1:0]  pos3;
    logic [HOLD_W-1:0]  pos6;
    logic [HOLD_W-1:0]  pos10;
    logic [1:0]         prefix;
    logic [FILL_W-1:0]  tbl_idx;
    logic [BYTE_W-1:0]  sym;
    logic [HOLD_W-1:0]  consume;
    logic [COUNT_W-1:0] emitted_inc;
    logic               slot_free;

    // symbol decode from the top of the held window
    always_comb
    begin
        pos2    = bits_held_reg - HOLD_W'(2);
        pos3    = bits_held_reg - HOLD_W'(3);
        pos6    = bits_held_reg - HOLD_W'(6);
        pos10   = bits_held_reg - HOLD_W'(10);
        prefix  = 2'(bit_buffer_reg >> pos2);
        tbl_idx = FILL_W'(2'(bit_buffer_reg >> pos3));
        sym     = code_table[tbl_idx];
        consume = HOLD_W'(3);
        unique case (prefix)
            2'b00, 2'b01:
            begin
                tbl_idx = FILL_W'(2'(bit_buffer_reg >> pos3));
                sym     = code_table[tbl_idx];
                consume = HOLD_W'(3);
            end
            2'b10:
            begin
                tbl_idx = FILL_W'(COMMON_LEN) + FILL_W'(4'(bit_buffer_reg >> pos6));
                sym     = code_table[tbl_idx];
                consume = HOLD_W'(6);
            end
            default:
            begin
                sym     = BYTE_W'(bit_buffer_reg >> pos10);
                consume = HOLD_W'(10);
            end
        endcase
    end

    assign emitted_inc = bytes_emitted_reg + COUNT_W'(1);
    assign slot_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        sts.job_finished  = job_finished_reg;
        sts.count_reached = bytes_emitted_reg >= out_count_reg;
        sts.table_full    = table_fill_reg == FILL_W'(TABLE_LEN);
        sts.table_last    = table_fill_reg == FILL_W'(TABLE_LEN - 1);
        sts.at_end        = item_end_reg;
        sts.buf_low       = bits_held_reg <= HOLD_W'(REFILL_LIMIT);
        sts.pads_full     = pad_cnt_reg == PAD_W'(PAD_LIMIT);
        sts.slot_free     = slot_free;
        sts.sym_done      = emitted_inc >= out_count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_count_reg     <= '0;
            table_fill_reg    <= '0;
            bit_buffer_reg    <= '0;
            bits_held_reg     <= '0;
            bytes_emitted_reg <= '0;
            job_finished_reg  <= 1'b0;
            pad_cnt_reg       <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                out_count_reg <= cfg_wdata;
            end
            if (cmd.load_item)
            begin
                pad_cnt_reg <= '0;
            end
            // clearing the job wins over any table, buffer or counter update in the same cycle
            if (cmd.clear_job)
            begin
                table_fill_reg    <= '0;
                bit_buffer_reg    <= '0;
                bits_held_reg     <= '0;
                bytes_emitted_reg <= '0;
                job_finished_reg  <= 1'b0;
            end
            else
            begin
                if (cmd.table_write)
                begin
                    table_fill_reg <= table_fill_reg + FILL_W'(1);
                end
                if (cmd.shift_in)
                begin
                    bit_buffer_reg <= {bit_buffer_reg[BUF_W-BYTE_W-1:0], item_byte_reg};
                    bits_held_reg  <= bits_held_reg + HOLD_W'(BYTE_W);
                end
                if (cmd.pad)
                begin
                    bit_buffer_reg <= {bit_buffer_reg[BUF_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
                    bits_held_reg  <= bits_held_reg + HOLD_W'(BYTE_W);
                    pad_cnt_reg    <= pad_cnt_reg + PAD_W'(1);
                end
                if (cmd.emit_sym)
                begin
                    bits_held_reg     <= bits_held_reg - consume;
                    bytes_emitted_reg <= emitted_inc;
                end
                if (cmd.set_finished)
                begin
                    job_finished_reg <= 1'b1;
                end
            end
            if (cmd.emit_sym || cmd.emit_status)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_byte_reg <= in_byte;
            item_end_reg  <= stream_end;
        end
        if (cmd.table_write)
        begin
            code_table[table_fill_reg] <= item_byte_reg;
        end
        if (cmd.emit_sym)
        begin
            out_byte_reg   <= sym;
            out_status_reg <= STATUS_DATA;
            out_last_reg   <= sts.sym_done;
        end
        else if (cmd.emit_status)
        begin
            out_byte_reg   <= '0;
            out_status_reg <= cmd.code;
            out_last_reg   <= 1'b1;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;

    a_hold_range: assert property (@(posedge clk) disable iff (!rst_n)
        bits_held_reg <= HOLD_W'(BUF_W) && table_fill_reg <= FILL_W'(TABLE_LEN))
        else $error("bit buffer or table fill out of range");

    a_pad_range: assert property (@(posedge clk) disable iff (!rst_n)
        pad_cnt_reg <= PAD_W'(PAD_LIMIT))
        else $error("pad count beyond limit");

endmodule

// ===== src/three_class_prefix_byte_decoder_unit.sv =====
// three_class_prefix_byte_decoder_unit: top level of the three-class prefix byte decoder
// depends on tcpbd_pkg, tcpbd_ifs (channels), tcpbd_ctrl and tcpbd_dp
//
// usage:
//   in_ch carries one compressed byte per item plus stream_end on the last byte
//   of a job; out_ch carries decoded bytes with status and last. the first 20
//   bytes of a job load the code table, later bytes feed a 32-bit bit buffer.
//   cfg_we/cfg_wdata write out_count, the number of bytes a job yields; write it
//   only while the block is idle.
// sequence:
//   one item at a time. an item is accepted, then classified: a table byte is
//   written to the code table, while a later byte is shifted into the buffer and
//   the refill loop emits decoded bytes while more than 24 bits are held, or on a
//   stream_end item pads with zero bytes, at most eight, before it closes. a
//   decoded byte goes from the loop state straight into the output register.
// reset: clears the job state, out_count and the output register; the code
//   table holds garbage until a job writes it.
// stall: a single output register holds one result; while out_ch is stalled
//   the sequencer waits, and the next item is accepted once the current item's
//   last result sits in the output register.

module three_class_prefix_byte_decoder_unit
    import tcpbd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    tcpbd_in_if.sink           in_ch,
    tcpbd_out_if.source        out_ch,
    input  logic               cfg_we,
    input  logic [COUNT_W-1:0] cfg_wdata
);

    dp_cmd_t    cmd;
    dp_status_t sts;
    logic       in_ready;

    tcpbd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tcpbd_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_byte    (in_ch.in_byte),
        .stream_end (in_ch.stream_end),
        .out_ready  (out_ch.ready),
        .out_valid  (out_ch.valid),
        .out_byte   (out_ch.out_byte),
        .out_status (out_ch.status),
        .out_last   (out_ch.last),
        .cmd        (cmd),
        .sts        (sts)
    );

    assign in_ch.ready = in_ready;

endmodule
